// ----- hw/rtl/tga_pkg.sv -----
package tga_pkg;

    typedef enum logic [1:0] {
        KIND_MAP   = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_START = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_IDX = 2'd1,
        ST_EARLY   = 2'd2
    } status_t;

    localparam logic [2:0] REG_PIXEL_BITS = 3'd0;
    localparam logic [2:0] REG_MAP_BITS   = 3'd1;
    localparam logic [2:0] REG_MAP_MODE   = 3'd2;
    localparam logic [2:0] REG_RLE_MODE   = 3'd3;
    localparam logic [2:0] REG_PIX_COUNT  = 3'd4;
    localparam logic [2:0] REG_MAP_ENTRIES = 3'd5;

    localparam logic [7:0] PKT_RUN_FLAG = 8'h80;
    localparam logic [7:0] PKT_LEN_MASK = 8'h7f;

    // byte count minus one
    function automatic logic [1:0] last_byte(input logic [5:0] bits);
        if (bits <= 6'd8) return 2'd0;
        else if (bits <= 6'd16) return 2'd1;
        else if (bits <= 6'd24) return 2'd2;
        else return 2'd3;
    endfunction

    function automatic logic [31:0] unpack(input logic [31:0] raw, input logic [1:0] lb);
        logic [31:0] res;
        unique case (lb)
            2'd0: res = {8'hff, raw[7:0], raw[7:0], raw[7:0]};
            2'd1: res = {8'hff, raw[14:10], 3'b000, raw[9:5], 3'b000, raw[4:0], 3'b000};
            2'd2: res = {8'hff, raw[23:0]};
            default: res = raw;
        endcase
        return res;
    endfunction

    // result of the decode stage, waiting for the map read
    typedef struct packed {
        logic        valid;
        logic        use_map;
        logic [31:0] colour;
        logic [7:0]  rep;
        status_t     status;
        logic        eoi;
    } stage_t;

endpackage

// ----- hw/rtl/tga_ram.sv -----
module tga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/tga_decode.sv -----
module tga_decode
    import tga_pkg::*;
#(
    parameter int MAP_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_en,
    input  logic        stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        final_req,
    input  logic [5:0]  pixel_bits,
    input  logic [5:0]  map_entry_bits,
    input  logic        map_mode,
    input  logic        rle_mode,
    input  logic [31:0] pixel_count,
    input  logic [8:0]  map_entries,
    output logic        map_we,
    output logic [7:0]  map_waddr,
    output logic [31:0] map_wdata,
    output logic        map_re,
    output logic [7:0]  map_raddr,
    output stage_t      stage
);
    logic [7:0]  wentry_reg, wentry_next;
    logic [1:0]  wbyte_reg, wbyte_next;
    logic [31:0] wacc_reg, wacc_next;
    logic [31:0] asm_reg, asm_next;
    logic [1:0]  pidx_reg, pidx_next;
    logic        hdr_reg, hdr_next;
    logic [7:0]  pleft_reg, pleft_next;
    logic        run_reg, run_next;
    logic [31:0] left_reg, left_next;
    logic        fin_reg, fin_next;
    stage_t      st;
    logic [31:0] asm_v, wacc_v;
    logic [1:0]  lb;
    logic [7:0]  rep, pl;
    logic        done;

    always_comb begin
        wentry_next = wentry_reg; wbyte_next = wbyte_reg; wacc_next = wacc_reg;
        asm_next = asm_reg; pidx_next = pidx_reg; hdr_next = hdr_reg;
        pleft_next = pleft_reg; run_next = run_reg; left_next = left_reg;
        fin_next = fin_reg;
        st = '0;
        map_we = 1'b0; map_re = 1'b0;
        map_raddr = asm_next[7:0];
        lb = last_byte(map_entry_bits);
        asm_v = '0; wacc_v = '0; rep = '0; pl = '0; done = 1'b0;
        // full entry accumulated locally, written once complete
        unique case (wbyte_reg)
            2'd0: wacc_v = {24'd0, data_byte};
            2'd1: wacc_v = {wacc_reg[31:16], data_byte, wacc_reg[7:0]};
            2'd2: wacc_v = {wacc_reg[31:24], data_byte, wacc_reg[15:0]};
            default: wacc_v = {data_byte, wacc_reg[23:0]};
        endcase
        map_wdata = wacc_v;
        map_waddr = wentry_reg;
        if (in_en) begin
            unique case (kind_t'(kind))
                KIND_START: begin
                    left_next = pixel_count; fin_next = 1'b0;
                    wentry_next = '0; wbyte_next = '0; asm_next = '0; pidx_next = '0;
                    hdr_next = 1'b1; pleft_next = '0; run_next = 1'b0;
                end
                KIND_MAP: begin
                    wacc_next = wacc_v;
                    map_we = ({24'd0, wentry_reg} < MAP_DEPTH);
                    if (wbyte_reg >= lb) begin
                        wbyte_next = '0;
                        wentry_next = wentry_reg + 8'd1;
                    end else begin
                        wbyte_next = wbyte_reg + 2'd1;
                        map_we = 1'b0;
                    end
                end
                KIND_PIXEL: begin
                    if (!fin_reg && left_reg != '0) begin
                        if (rle_mode && hdr_reg) begin
                            run_next = (data_byte & PKT_RUN_FLAG) != '0;
                            pleft_next = (data_byte & PKT_LEN_MASK) + 8'd1;
                            hdr_next = 1'b0;
                            pidx_next = '0;
                        end else begin
                            unique case (pidx_reg)
                                2'd0: asm_v = {24'd0, data_byte};
                                2'd1: asm_v = {asm_reg[31:16], data_byte, asm_reg[7:0]};
                                2'd2: asm_v = {asm_reg[31:24], data_byte, asm_reg[15:0]};
                                default: asm_v = {data_byte, asm_reg[23:0]};
                            endcase
                            asm_next = asm_v;
                            if (pidx_reg >= last_byte(pixel_bits)) begin
                                pidx_next = '0;
                                map_raddr = asm_v[7:0];
                                if (map_mode && ({1'b0, asm_v[7:0]} >= map_entries
                                        || {24'd0, asm_v[7:0]} >= MAP_DEPTH)) begin
                                    fin_next = 1'b1; done = 1'b1;
                                    st.valid = 1'b1; st.status = ST_BAD_IDX; st.eoi = 1'b1;
                                end else begin
                                    map_re = map_mode;
                                    st.use_map = map_mode;
                                    st.colour = unpack(asm_v, last_byte(pixel_bits));
                                    if (rle_mode) begin
                                        pl = (pleft_reg == '0) ? 8'd1 : pleft_reg;
                                        if (run_reg) begin
                                            rep = pl; pl = '0;
                                        end else begin
                                            rep = 8'd1; pl = pl - 8'd1;
                                        end
                                        pleft_next = pl;
                                        if (pl == '0) hdr_next = 1'b1;
                                    end else begin
                                        rep = 8'd1;
                                    end
                                    if ({24'd0, rep} > left_reg) rep = left_reg[7:0];
                                    left_next = left_reg - {24'd0, rep};
                                    if (left_next == '0) fin_next = 1'b1;
                                    st.valid = 1'b1; st.rep = rep;
                                    st.status = ST_OK; st.eoi = fin_next;
                                end
                            end else begin
                                pidx_next = pidx_reg + 2'd1;
                            end
                        end
                        if (!done && final_req && !fin_next) begin
                            fin_next = 1'b1;
                            st = '0;
                            map_re = 1'b0;
                            st.valid = 1'b1; st.status = ST_EARLY; st.eoi = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wentry_reg <= '0; wbyte_reg <= '0; asm_reg <= '0; pidx_reg <= '0;
            hdr_reg <= 1'b1; pleft_reg <= '0; run_reg <= 1'b0; left_reg <= '0;
            fin_reg <= 1'b0; stage <= '0; wacc_reg <= '0;
        end else begin
            wentry_reg <= wentry_next; wbyte_reg <= wbyte_next; wacc_reg <= wacc_next;
            asm_reg <= asm_next; pidx_reg <= pidx_next; hdr_reg <= hdr_next;
            pleft_reg <= pleft_next; run_reg <= run_next; left_reg <= left_next;
            fin_reg <= fin_next;
            // a waiting result stays put while the output register is blocked
            if (in_en) stage <= st;
            else if (!stall) stage.valid <= 1'b0;
        end
    end
endmodule

// ----- hw/rtl/tga_pixel_stream_decoder_top.sv -----
// Results pass the stage register (with the map read), then the output register.
// Throughput: one byte per cycle unless s_ready is low; the colour map RAM has
// one read and one write port, and a map write lands before any later read.
// Output is a skid-free two-entry path: input stalls only while a result waits.
// Reset (aresetn low, synchronous): registers to defaults, image state cleared;
// colour map contents undefined until written.
module tga_pixel_stream_decoder_top
    import tga_pkg::*;
#(
    parameter int MAP_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_argb,
    output logic [7:0]  m_repeat_res,
    output logic [1:0]  m_status,
    output logic        m_end_of_image,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [5:0]  pbits_reg, mbits_reg;
    logic        mmode_reg, rle_reg;
    logic [31:0] pcount_reg;
    logic [8:0]  mentries_reg;
    logic        map_we, map_re;
    logic [7:0]  map_waddr, map_raddr;
    logic [31:0] map_wdata, map_rdata;
    stage_t      stage;
    logic        in_en, hold;
    logic [31:0] colour;
    logic        ov_reg;
    logic [31:0] oargb_reg;
    logic [7:0]  orep_reg;
    logic [1:0]  ost_reg;
    logic        oeoi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pbits_reg <= 6'd24; mbits_reg <= 6'd24; mmode_reg <= 1'b0;
            rle_reg <= 1'b0; pcount_reg <= 32'd1; mentries_reg <= 9'd256;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PIXEL_BITS:  pbits_reg <= cfg_data[5:0];
                REG_MAP_BITS:    mbits_reg <= cfg_data[5:0];
                REG_MAP_MODE:    mmode_reg <= cfg_data[0];
                REG_RLE_MODE:    rle_reg <= cfg_data[0];
                REG_PIX_COUNT:   pcount_reg <= cfg_data;
                REG_MAP_ENTRIES: mentries_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // stage result stalls when output register is full and not drained
    assign hold = ov_reg && !m_ready;
    assign s_ready = !(stage.valid && hold);
    assign in_en = s_valid && s_ready;

    tga_ram #(.WIDTH(32), .DEPTH(256)) u_map (
        .aclk(aclk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .re(map_re), .raddr(map_raddr), .rdata(map_rdata)
    );

    tga_decode #(.MAP_DEPTH(MAP_DEPTH)) u_dec (
        .aclk(aclk), .aresetn(aresetn), .in_en(in_en), .stall(hold),
        .kind(s_kind), .data_byte(s_data_byte), .final_req(s_final_req),
        .pixel_bits(pbits_reg), .map_entry_bits(mbits_reg), .map_mode(mmode_reg),
        .rle_mode(rle_reg), .pixel_count(pcount_reg), .map_entries(mentries_reg),
        .map_we(map_we), .map_waddr(map_waddr), .map_wdata(map_wdata),
        .map_re(map_re), .map_raddr(map_raddr), .stage(stage)
    );

    assign colour = stage.use_map ? unpack(map_rdata, last_byte(mbits_reg)) : stage.colour;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (!hold) begin
            ov_reg <= stage.valid;
            oargb_reg <= colour;
            orep_reg <= stage.rep;
            ost_reg <= stage.status;
            oeoi_reg <= stage.eoi;
        end
    end

    assign m_valid = ov_reg;
    assign m_argb = oargb_reg;
    assign m_repeat_res = orep_reg;
    assign m_status = ost_reg;
    assign m_end_of_image = oeoi_reg;

    a_err_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_end_of_image && m_repeat_res == 8'd0)
        else $error("error result without end of image");
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        stage.valid && hold |=> stage.valid && $stable(stage))
        else $error("stage result lost");
    a_ok_rep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> m_repeat_res != 8'd0)
        else $error("pixel result with zero repeat");
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import tga_pkg::*;

    class tga_scoreboard;
        // decoder state
        logic [5:0]  pix_bits, map_bits;
        logic        map_on, rle_on;
        logic [31:0] img_pixels;
        logic [8:0]  map_valid;
        logic [31:0] cmap [256];
        logic [7:0]  map_ent;
        logic [1:0]  map_byte;
        logic [31:0] asm_word;
        logic [1:0]  asm_idx;
        logic        want_hdr;
        logic [7:0]  run_left;
        logic        run_flag;
        logic [31:0] remain;
        logic        done;
        logic [31:0] exp_argb[$];
        logic [7:0]  exp_rep[$];
        logic [1:0]  exp_st[$];
        logic        exp_eoi[$];
        int          errors;

        function new();
            pix_bits = 6'd24; map_bits = 6'd24; map_on = 1'b0; rle_on = 1'b0;
            img_pixels = 32'd1; map_valid = 9'd256;
            foreach (cmap[i]) cmap[i] = '0;
            map_ent = '0; map_byte = '0; asm_word = '0; asm_idx = '0;
            want_hdr = 1'b1; run_left = '0; run_flag = 1'b0; remain = '0; done = 1'b0;
            errors = 0;
        endfunction

        function logic [1:0] nbytes_m1(logic [5:0] b);
            if (b <= 6'd8) return 2'd0;
            if (b <= 6'd16) return 2'd1;
            if (b <= 6'd24) return 2'd2;
            return 2'd3;
        endfunction

        function logic [31:0] to_argb(logic [31:0] raw, logic [1:0] lb);
            case (lb)
                2'd0: return {8'hff, raw[7:0], raw[7:0], raw[7:0]};
                2'd1: return {8'hff, raw[14:10], 3'b0, raw[9:5], 3'b0, raw[4:0], 3'b0};
                2'd2: return {8'hff, raw[23:0]};
                default: return raw;
            endcase
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_PIXEL_BITS:  pix_bits = v[5:0];
                REG_MAP_BITS:    map_bits = v[5:0];
                REG_MAP_MODE:    map_on = v[0];
                REG_RLE_MODE:    rle_on = v[0];
                REG_PIX_COUNT:   img_pixels = v;
                REG_MAP_ENTRIES: map_valid = v[8:0];
                default: ;
            endcase
        endfunction

        function void push(logic [31:0] a, logic [7:0] r, logic [1:0] s, logic e);
            exp_argb.push_back(a); exp_rep.push_back(r);
            exp_st.push_back(s); exp_eoi.push_back(e);
        endfunction

        function void note_input(logic [1:0] kind, logic [7:0] d, logic fin);
            logic [31:0] colour;
            logic [31:0] rep;
            logic        got;
            logic [7:0]  ix;
            got = 1'b0; colour = '0; rep = '0;
            if (kind == KIND_START) begin
                remain = img_pixels; done = 1'b0; map_ent = '0; map_byte = '0;
                asm_word = '0; asm_idx = '0; want_hdr = 1'b1; run_left = '0;
                run_flag = 1'b0;
                return;
            end
            if (kind == KIND_MAP) begin
                if (map_byte == 2'd0) cmap[map_ent] = {24'b0, d};
                else cmap[map_ent] = cmap[map_ent] | (32'(d) << (8 * map_byte));
                if (map_byte >= nbytes_m1(map_bits)) begin
                    map_byte = '0; map_ent = map_ent + 8'd1;
                end else map_byte = map_byte + 2'd1;
                return;
            end
            if (kind != KIND_PIXEL || done || remain == '0) return;
            if (rle_on && want_hdr) begin
                run_flag = d[7]; run_left = {1'b0, d[6:0]} + 8'd1;
                want_hdr = 1'b0; asm_idx = '0;
            end else begin
                if (asm_idx == 2'd0) asm_word = {24'b0, d};
                else asm_word = asm_word | (32'(d) << (8 * asm_idx));
                if (asm_idx >= nbytes_m1(pix_bits)) begin
                    asm_idx = '0;
                    if (map_on) begin
                        ix = asm_word[7:0];
                        if ({1'b0, ix} >= map_valid) begin
                            done = 1'b1; push('0, '0, ST_BAD_IDX, 1'b1); return;
                        end
                        colour = to_argb(cmap[ix], nbytes_m1(map_bits));
                    end else colour = to_argb(asm_word, nbytes_m1(pix_bits));
                    if (rle_on) begin
                        if (run_left == 8'd0) run_left = 8'd1;
                        if (run_flag) begin rep = 32'(run_left); run_left = '0; end
                        else begin rep = 32'd1; run_left = run_left - 8'd1; end
                        if (run_left == 8'd0) want_hdr = 1'b1;
                    end else rep = 32'd1;
                    if (rep > remain) rep = remain;
                    remain = remain - rep;
                    if (remain == '0) done = 1'b1;
                    got = 1'b1;
                end else asm_idx = asm_idx + 2'd1;
            end
            if (fin && !done) begin
                done = 1'b1; push('0, '0, ST_EARLY, 1'b1);
            end else if (got) push(colour, rep[7:0], ST_OK, done);
        endfunction

        function void check(logic [31:0] a, logic [7:0] r, logic [1:0] s, logic e);
            if (exp_argb.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result argb=%h rep=%0d st=%0d", a, r, s);
                return;
            end
            if (a !== exp_argb[0] || r !== exp_rep[0] || s !== exp_st[0]
                    || e !== exp_eoi[0]) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp argb=%h rep=%0d st=%0d eoi=%0d, got %h %0d %0d %0d",
                             exp_argb[0], exp_rep[0], exp_st[0], exp_eoi[0], a, r, s, e);
            end
            void'(exp_argb.pop_front()); void'(exp_rep.pop_front());
            void'(exp_st.pop_front()); void'(exp_eoi.pop_front());
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0, s_ready, s_final_req = 0;
    logic [1:0]  s_kind = KIND_MAP;
    logic [7:0]  s_data_byte = 0;
    logic        m_valid, m_ready = 0, m_end_of_image;
    logic [31:0] m_argb;
    logic [7:0]  m_repeat_res;
    logic [1:0]  m_status;
    logic        cfg_valid = 0, cfg_ready;
    logic [2:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;

    tga_scoreboard sb = new();
    int  idle_cycles = 0;
    int  n_results = 0;
    int  n_items = 0;
    bit  stim_done = 0;

    tga_pixel_stream_decoder_top u_dut (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check(m_argb, m_repeat_res, m_status, m_end_of_image);
            n_results++;
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 20000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int w;
        forever begin
            @(negedge aclk);
            if (!stim_done && $urandom_range(0, 3) == 0) w = 0;
            else w = $urandom_range(0, 13);
            if (w > 0) begin
                m_ready <= 0;
                repeat (w) @(negedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    bit burst;

    // called at a falling edge; valid stays up until the next driver takes over
    task automatic send_byte(logic [1:0] kind, logic [7:0] d, logic fin = 1'b0);
        int w;
        w = burst ? 0 : $urandom_range(0, 13);
        cfg_valid <= 0;
        if (w > 0) begin
            s_valid <= 0;
            repeat (w) @(negedge aclk);
        end
        s_valid <= 1; s_kind <= kind; s_data_byte <= d; s_final_req <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(kind, d, fin);
        n_items++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        cfg_valid <= 0;
        while (sb.exp_argb.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] v);
        s_valid <= 0;
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, v);
        @(negedge aclk);
    endtask

    function automatic logic [5:0] rand_bits();
        case ($urandom_range(0, 4))
            0: return 6'd8;
            1: return 6'd15;
            2: return 6'd16;
            3: return 6'd24;
            default: return 6'd32;
        endcase
    endfunction

    // low byte is the map index; mostly valid, sometimes out of range
    function automatic logic [7:0] pix_byte(logic [8:0] ents, int k);
        if (k != 0) return 8'($urandom);
        if ($urandom_range(0, 40) == 0) return 8'($urandom);
        return 8'($urandom_range(0, int'(ents) - 1));
    endfunction

    // one image: map fill, then pixel stream (well formed mostly)
    task automatic run_image(logic [5:0] pb, logic [5:0] mb, logic mm, logic rl,
                             logic [31:0] cnt, logic [8:0] ents, int extra);
        int nb, mnb, k, p, len, fill;
        bit cut;
        set_reg(REG_PIXEL_BITS, 32'(pb));
        set_reg(REG_MAP_BITS, 32'(mb));
        set_reg(REG_MAP_MODE, 32'(mm));
        set_reg(REG_RLE_MODE, 32'(rl));
        set_reg(REG_PIX_COUNT, cnt);
        set_reg(REG_MAP_ENTRIES, 32'(ents));
        burst = $urandom_range(0, 3) == 0;
        send_byte(KIND_START, 8'($urandom));
        nb = int'(sb.nbytes_m1(pb)) + 1;
        mnb = int'(sb.nbytes_m1(mb)) + 1;
        // in map mode every entry below the limit is written so no valid index reads an unwritten one
        fill = mm ? int'(ents) : int'($urandom_range(0, 3));
        for (k = 0; k < fill * mnb; k++) send_byte(KIND_MAP, 8'($urandom));
        cut = $urandom_range(0, 7) == 0;
        p = 0;
        while (p < cnt) begin
            if (rl) begin
                len = $urandom_range(1, 128);
                if ($urandom_range(0, 1)) begin
                    send_byte(KIND_PIXEL, 8'h80 | 8'(len - 1));
                    for (k = 0; k < nb; k++)
                        send_byte(KIND_PIXEL, mm ? pix_byte(ents, k) : 8'($urandom));
                end else begin
                    if (len > 6) len = $urandom_range(1, 6);
                    send_byte(KIND_PIXEL, 8'(len - 1));
                    for (int j = 0; j < len * nb; j++)
                        send_byte(KIND_PIXEL, mm ? pix_byte(ents, j % nb) : 8'($urandom));
                end
                p += len;
            end else begin
                for (k = 0; k < nb; k++)
                    send_byte(KIND_PIXEL, mm ? pix_byte(ents, k) : 8'($urandom),
                              cut && p + 1 >= cnt / 2 && k == 0 && nb > 1);
                p++;
            end
        end
        for (k = 0; k < extra; k++)
            send_byte($urandom_range(0, 3) == 0 ? KIND_NONE : KIND_PIXEL,
                      8'($urandom), 1'($urandom_range(0, 1)));
        drain();
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        burst = 0;
        // directed
        run_image(6'd8, 6'd8, 1'b0, 1'b0, 32'd3, 9'd256, 0);
        send_byte(KIND_PIXEL, 8'hff, 1'b1);
        send_byte(KIND_PIXEL, 8'h00, 1'b0);
        drain();
        run_image(6'd16, 6'd24, 1'b0, 1'b0, 32'd2, 9'd256, 0);
        run_image(6'd32, 6'd32, 1'b0, 1'b1, 32'd5, 9'd256, 2);
        run_image(6'd24, 6'd16, 1'b1, 1'b0, 32'd2, 9'd1, 0);
        run_image(6'd15, 6'd32, 1'b1, 1'b1, 32'd1, 9'd40, 0);
        // early end inside an unfinished image
        set_reg(REG_RLE_MODE, 32'd0);
        set_reg(REG_PIX_COUNT, 32'hffffffff);
        send_byte(KIND_START, 8'h00);
        send_byte(KIND_PIXEL, 8'h12);
        send_byte(KIND_PIXEL, 8'h34, 1'b1);
        send_byte(KIND_NONE, 8'h55, 1'b1);
        drain();
        // random images
        while (n_items < 1600) begin
            run_image(rand_bits(), rand_bits(), $urandom_range(0, 3) == 0,
                      1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : $urandom_range(5, 60),
                      $urandom_range(0, 4) == 0 ? 9'($urandom_range(1, 8))
                                                : 9'($urandom_range(9, 48)),
                      $urandom_range(0, 3));
        end
        stim_done = 1;
        drain();
        repeat (20) @(negedge aclk);
        if (sb.errors == 0 && sb.exp_argb.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
